### hdl/lpft_pkg.sv
// Shared types and constants for the LRU page-frame table.
// Used by lpft_scan and lru_page_frame_table; depends on nothing else.
package lpft_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = 4;
  localparam int RANK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 5;
  localparam int FAULT_W   = 32;

  localparam logic [CFG_W-1:0]   CAP_RESET = CFG_W'(4);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic [15:0] page_number;
    logic        first_of_sequence;
  } req_t;

  typedef struct packed {
    logic        page_fault;
    logic [3:0]  frame_slot;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
    logic [4:0]  resident_count;
  } rsp_t;

  // Accumulated findings of one pass over the frames.
  typedef struct packed {
    logic   hit;
    slot_t  hit_slot;
    count_t count;
    logic   free_found;
    slot_t  free_slot;
    logic   vic_found;
    slot_t  vic_slot;
    rank_t  vic_rank;
    page_t  vic_page;
  } scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

endpackage

### hdl/lru_page_frame_table.sv
// LRU page-frame table, top level. Depends on lpft_pkg and lpft_scan.
// A request passes through the scan, memory read drain and update states; update waits
// until the previous response has been taken, and the response is registered.
// The single frame scan unit serves one request at a time: a new one is accepted only in idle.
// Reset (rst, synchronous): all frames empty, fault count zero, capacity 4.
module lru_page_frame_table import lpft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]   frames_in_use;
  logic [FRAMES-1:0]  frame_valid;
  rank_t              recency_rank [FRAMES];
  logic [FAULT_W-1:0] fault_counter;
  page_t              frame_page [FRAMES];

  page_t  page;
  slot_t  scan_slot;
  slot_t  rd_slot;
  logic   rd_step;
  page_t  rd_page;
  scan_t  scan;

  logic   accept;
  logic   scan_start;
  logic   update;
  logic   scan_last;

  count_t cap;
  logic   fill;
  slot_t  slot;
  rank_t  old_rank;
  count_t count_after;
  logic [FAULT_W-1:0] fault_next;

  assign cfg_ready  = !rst;
  assign accept     = req_valid && req_ready;
  assign scan_start = accept;
  assign scan_last  = (scan_slot == SLOT_W'(FRAMES - 1));

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    update     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = !rst;
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Hold until the previous response has been taken.
        if (!rsp_valid || rsp_ready) begin
          update     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan address and the registered memory read feeding the scan unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_step <= 1'b0;
    end else begin
      rd_step <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_slot <= '0;
      page      <= req.page_number;
    end else if (state == ST_SCAN) begin
      scan_slot <= scan_slot + SLOT_W'(1);
    end
    rd_slot <= scan_slot;
  end

  always_ff @(posedge clk) begin
    rd_page <= frame_page[scan_slot];
    if (update) begin
      frame_page[slot] <= page;
    end
  end

  lpft_scan u_scan (
    .clk        (clk),
    .start      (scan_start),
    .step       (rd_step),
    .step_slot  (rd_slot),
    .step_valid (frame_valid[rd_slot]),
    .step_rank  (recency_rank[rd_slot]),
    .step_page  (rd_page),
    .page       (page),
    .result     (scan)
  );

  // Decision made once the scan is complete.
  always_comb begin
    if (frames_in_use == '0) begin
      cap = COUNT_W'(1);
    end else if (COUNT_W'(frames_in_use) > COUNT_W'(FRAMES)) begin
      cap = COUNT_W'(FRAMES);
    end else begin
      cap = COUNT_W'(frames_in_use);
    end
    fill        = !scan.hit && (scan.count < cap);
    slot        = scan.hit ? scan.hit_slot : (fill ? scan.free_slot : scan.vic_slot);
    count_after = fill ? scan.count + COUNT_W'(1) : scan.count;
    if (scan.hit) begin
      old_rank = recency_rank[scan.hit_slot];
    end else if (fill) begin
      old_rank = RANK_W'(scan.count);
    end else begin
      old_rank = scan.vic_rank;
    end
    if (!scan.hit && fault_counter != FAULT_MAX) begin
      fault_next = fault_counter + FAULT_W'(1);
    end else begin
      fault_next = fault_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      fault_counter <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (accept && req.first_of_sequence) begin
      frame_valid   <= '0;
      fault_counter <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (update) begin
      fault_counter <= fault_next;
      frame_valid[slot] <= 1'b1;
      // Frames more recent than the touched one age by one.
      for (int i = 0; i < FRAMES; i++) begin
        if (slot_t'(i) == slot) begin
          recency_rank[i] <= '0;
        end else if (frame_valid[i] && recency_rank[i] < old_rank) begin
          recency_rank[i] <= recency_rank[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (update) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      rsp.page_fault     <= !scan.hit;
      rsp.frame_slot     <= slot;
      rsp.evicted_valid  <= !scan.hit && !fill;
      rsp.evicted_page   <= (!scan.hit && !fill) ? scan.vic_page : '0;
      rsp.fault_total    <= fault_next;
      rsp.resident_count <= count_after;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("request accepted while a previous one is in progress");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted_valid |-> rsp.page_fault)
    else $error("eviction reported without a page fault");

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (rst)
    update && scan.hit |-> frame_valid[scan.hit_slot])
    else $error("hit reported on an empty frame");

  a_no_lost_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("pending response dropped");

endmodule

### hdl/lpft_scan.sv
// Frame scan unit: examines one frame per cycle and accumulates hit, count,
// lowest free slot and LRU victim. Depends on lpft_pkg.
module lpft_scan import lpft_pkg::*; (
  input  logic   clk,
  input  logic   start,
  input  logic   step,
  input  slot_t  step_slot,
  input  logic   step_valid,
  input  rank_t  step_rank,
  input  page_t  step_page,
  input  page_t  page,
  output scan_t  result
);

  scan_t acc;
  scan_t acc_next;

  always_comb begin
    acc_next = acc;
    if (start) begin
      acc_next = '0;
    end else if (step) begin
      if (step_valid) begin
        acc_next.count = acc.count + COUNT_W'(1);
        if (!acc.hit && step_page == page) begin
          acc_next.hit      = 1'b1;
          acc_next.hit_slot = step_slot;
        end
        // The first frame with the largest rank is the victim.
        if (!acc.vic_found || step_rank > acc.vic_rank) begin
          acc_next.vic_found = 1'b1;
          acc_next.vic_slot  = step_slot;
          acc_next.vic_rank  = step_rank;
          acc_next.vic_page  = step_page;
        end
      end else if (!acc.free_found) begin
        acc_next.free_found = 1'b1;
        acc_next.free_slot  = step_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  assign result = acc;

endmodule

### dv/lru_page_frame_table_tb.sv
// Testbench for lru_page_frame_table: directed and random page references under
// random back-pressure, checked against a scoreboard with its own LRU table.
// Depends on lpft_pkg and the lru_page_frame_table RTL.
`timescale 1ns / 1ps

module lru_page_frame_table_tb;
  import lpft_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1450;

  // Keeps a private copy of the frame table and the queue of responses it predicts.
  class frame_scoreboard;
    page_t page_of[FRAMES];
    bit held[FRAMES];
    rank_t age[FRAMES];
    logic [FAULT_W-1:0] faults;
    logic [CFG_W-1:0] capacity;
    rsp_t awaited_replies[$];
    int errors;

    function new();
      clear_frames();
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void clear_frames();
      for (int i = 0; i < FRAMES; i++) begin
        page_of[i] = '0;
        held[i] = 1'b0;
        age[i] = '0;
      end
      faults = '0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] v);
      capacity = v;
    endfunction

    // Slot s becomes the most recent; frames more recent than its old rank age by one.
    function void promote(int s, int old_rank);
      for (int i = 0; i < FRAMES; i++)
        if (held[i] && i != s && int'(age[i]) < old_rank) age[i] = age[i] + 1'b1;
      age[s] = '0;
    endfunction

    function rsp_t lookup_page(req_t r);
      rsp_t o;
      page_t pg;
      int cap;
      int count;
      int slot;
      int oldest;
      bit hit;
      bit found;
      pg = r.page_number;
      if (r.first_of_sequence) clear_frames();
      cap = int'(capacity);
      if (cap == 0) cap = 1;
      if (cap > FRAMES) cap = FRAMES;
      count = 0;
      hit = 1'b0;
      slot = 0;
      for (int i = 0; i < FRAMES; i++) begin
        if (held[i]) begin
          count++;
          if (!hit && page_of[i] == pg) begin
            hit = 1'b1;
            slot = i;
          end
        end
      end
      o = '0;
      if (hit) begin
        promote(slot, int'(age[slot]));
      end else begin
        if (count < cap) begin
          for (int i = FRAMES - 1; i >= 0; i--)
            if (!held[i]) slot = i;
          held[slot] = 1'b1;
          page_of[slot] = pg;
          age[slot] = rank_t'(count);
          promote(slot, count);
          count++;
        end else begin
          // Victim is the valid frame with the largest rank, lowest index on a tie.
          found = 1'b0;
          oldest = 0;
          for (int i = 0; i < FRAMES; i++) begin
            if (held[i] && (!found || int'(age[i]) > oldest)) begin
              oldest = int'(age[i]);
              slot = i;
              found = 1'b1;
            end
          end
          o.evicted_valid = 1'b1;
          o.evicted_page = page_of[slot];
          page_of[slot] = pg;
          promote(slot, oldest);
        end
        if (faults != FAULT_MAX) faults = faults + 1'b1;
      end
      o.page_fault = !hit;
      o.frame_slot = slot_t'(slot);
      o.fault_total = faults;
      o.resident_count = count_t'(count);
      return o;
    endfunction

    function void note_request(req_t r);
      awaited_replies.push_back(lookup_page(r));
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (awaited_replies.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = awaited_replies.pop_front();
      if (got.page_fault !== want.page_fault)
        report_mismatch($sformatf("page_fault %0b, expected %0b", got.page_fault,
                                  want.page_fault));
      if (got.frame_slot !== want.frame_slot)
        report_mismatch($sformatf("frame_slot %0d, expected %0d", got.frame_slot,
                                  want.frame_slot));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch($sformatf("evicted_valid %0b, expected %0b", got.evicted_valid,
                                  want.evicted_valid));
      if (got.evicted_page !== want.evicted_page)
        report_mismatch($sformatf("evicted_page %h, expected %h", got.evicted_page,
                                  want.evicted_page));
      if (got.fault_total !== want.fault_total)
        report_mismatch($sformatf("fault_total %0d, expected %0d", got.fault_total,
                                  want.fault_total));
      if (got.resident_count !== want.resident_count)
        report_mismatch($sformatf("resident_count %0d, expected %0d", got.resident_count,
                                  want.resident_count));
    endtask

    function int outstanding();
      return awaited_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  frame_scoreboard sb = new();
  bit tx_busy = 1'b0;
  bit rx_busy = 1'b0;
  int rx_hold = 0;
  int cycles = 0;

  lru_page_frame_table uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // A response accepted on the same edge as a request always belongs to an older one.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (req_valid && req_ready) sb.note_request(req);
    end
  end

  // Response side: a random stall before each response when rx_busy is set, or a long hold when asked.
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = rx_busy ? $urandom_range(0, 8) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_request(input logic [15:0] page, input logic first);
    int gap;
    req_t item;
    item.page_number = page;
    item.first_of_sequence = first;
    gap = tx_busy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every predicted response has arrived.
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    page_t pool[20];
    int pool_n;
    int eff_cap;
    int phase;
    int sent;
    int burst;
    int pick;
    logic [CFG_W-1:0] cap_val;
    logic [15:0] pg;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, starting at the reset capacity of four.
    send_request(16'h0000, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b0);
    send_request(16'h1234, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'hFFFF, 1'b0);
    // Zero capacity acts as one, with four pages already resident.
    write_capacity(5'd0);
    send_request(16'h0001, 1'b0);
    send_request(16'h0001, 1'b0);
    send_request(16'h8000, 1'b1);
    send_request(16'h8001, 1'b0);
    // Capacity above the frame count acts as the frame count; free slots fill again.
    write_capacity(5'd31);
    send_request(16'h0100, 1'b0);
    send_request(16'h0200, 1'b0);
    send_request(16'h0300, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h0400, 1'b0);
    write_capacity(5'd16);
    send_request(16'h7FFF, 1'b0);
    // Capacity lowered below the resident count: misses evict, count holds.
    write_capacity(5'd2);
    send_request(16'h4000, 1'b0);
    send_request(16'h4000, 1'b0);
    send_request(16'h0002, 1'b1);
    send_request(16'h0002, 1'b0);

    // Random phases: a capacity, a working set of pages, and a burst of requests.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      case (phase)
        0: cap_val = 5'd1;
        1: cap_val = 5'd16;
        2: cap_val = 5'd17;
        3: cap_val = 5'd0;
        4: cap_val = 5'd31;
        default: cap_val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                                       : CFG_W'($urandom_range(1, 8));
      endcase
      if (phase == 6) begin
        // Sender pauses for the table to drain completely before going on.
        settle();
      end else begin
        write_capacity(cap_val);
      end
      eff_cap = (cap_val == 0) ? 1 : (cap_val > FRAMES) ? FRAMES : cap_val;
      pool_n = eff_cap + $urandom_range(0, 3);
      for (int k = 0; k < pool_n; k++) begin
        // Some pages differ from the previous one in one bit only.
        if (k > 0 && $urandom_range(0, 3) == 0)
          pool[k] = pool[k-1] ^ (16'h1 << $urandom_range(0, 15));
        else
          pool[k] = page_t'($urandom);
      end
      tx_busy = (phase % 4 == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      rx_busy = (phase % 4 == 2) ? 1'b0 : ($urandom_range(0, 2) != 0);
      if (phase == 3 || phase == 12) begin
        // Long receiver hold while the sender keeps offering requests.
        tx_busy = 1'b0;
        rx_hold = 250;
      end
      burst = $urandom_range(20, 80);
      for (int n = 0; n < burst; n++) begin
        pick = $urandom_range(0, 99);
        pg = pool[$urandom_range(0, pool_n - 1)];
        if (pick >= 90) pg = page_t'($urandom);
        send_request(pg, (n == 0 && $urandom_range(0, 2) == 0) || pick < 3);
        sent++;
      end
      phase++;
    end

    settle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
